### hdl/psp_pkg.sv
// Package for the 2D point-to-segment projection core.
// Holds widths, the front-to-back item type and shared constants; no dependencies.
package psp_pkg;
  localparam int unsigned CoordBits = 32;
  localparam int unsigned RatioFrac = 16;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned DotBits   = ProdBits + 1;
  localparam int unsigned NumBits   = DotBits + RatioFrac;
  localparam int unsigned QuotBits  = NumBits;
  localparam int unsigned LimitExp  = CoordBits + 1 + RatioFrac;
  localparam int unsigned RmagBits  = LimitExp + 1;
  localparam int unsigned OffBits   = CoordBits + 3;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrBits  = 2;

  typedef struct packed {
    logic signed [CoordBits-1:0] sx;
    logic signed [CoordBits-1:0] sz;
    logic signed [CoordBits-1:0] ex;
    logic signed [CoordBits-1:0] ez;
    logic signed [DiffBits-1:0]  dx;
    logic signed [DiffBits-1:0]  dz;
    logic signed [DotBits-1:0]   dot;
    logic        [DotBits-1:0]   len2;
  } job_t;

  typedef struct packed {
    logic                        on_segment;
    logic signed [CoordBits-1:0] seg_x;
    logic signed [CoordBits-1:0] seg_z;
    logic signed [CoordBits-1:0] line_x;
    logic signed [CoordBits-1:0] line_z;
    logic                        degenerate;
  } res_t;

  function automatic logic signed [CoordBits-1:0] sat_coord(
    input logic signed [CoordBits+3:0] v
  );
    logic signed [CoordBits+3:0] hi;
    logic signed [CoordBits+3:0] lo;
    hi = (CoordBits+4)'((64'sd1 <<< (CoordBits-1)) - 64'sd1);
    lo = -hi - (CoordBits+4)'(1);
    if (v > hi) return hi[CoordBits-1:0];
    if (v < lo) return lo[CoordBits-1:0];
    return v[CoordBits-1:0];
  endfunction
endpackage

### hdl/psp_front.sv
// Front part: accepts a query word, forms the segment deltas, dot product and squared length.
// Three registered stages; depends on psp_pkg.
module psp_front import psp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [6*CoordBits-1:0] in_data_i,
  input  logic                 adv_i,
  output logic                 out_valid_o,
  output job_t                 out_job_o
);
  logic [2:0] v_q;
  logic signed [CoordBits-1:0] sx1_q, sz1_q, ex1_q, ez1_q;
  logic signed [DiffBits-1:0] dx1_q, dz1_q, qx1_q, qz1_q;
  logic signed [CoordBits-1:0] sx2_q, sz2_q, ex2_q, ez2_q;
  logic signed [DiffBits-1:0] dx2_q, dz2_q;
  logic signed [ProdBits-1:0] px2_q, pz2_q;
  logic [ProdBits-1:0] lx2_q, lz2_q;
  job_t job_q;
  logic signed [CoordBits-1:0] px, pz, sx, sz, ex, ez;

  assign {ez, ex, sz, sx, pz, px} = in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sx1_q <= sx; sz1_q <= sz; ex1_q <= ex; ez1_q <= ez;
      dx1_q <= DiffBits'(ex) - DiffBits'(sx);
      dz1_q <= DiffBits'(ez) - DiffBits'(sz);
      qx1_q <= DiffBits'(px) - DiffBits'(sx);
      qz1_q <= DiffBits'(pz) - DiffBits'(sz);
      sx2_q <= sx1_q; sz2_q <= sz1_q; ex2_q <= ex1_q; ez2_q <= ez1_q;
      dx2_q <= dx1_q; dz2_q <= dz1_q;
      px2_q <= ProdBits'(qx1_q * dx1_q);
      pz2_q <= ProdBits'(qz1_q * dz1_q);
      lx2_q <= ProdBits'(dx1_q * dx1_q);
      lz2_q <= ProdBits'(dz1_q * dz1_q);
      job_q.sx <= sx2_q; job_q.sz <= sz2_q; job_q.ex <= ex2_q; job_q.ez <= ez2_q;
      job_q.dx <= dx2_q; job_q.dz <= dz2_q;
      job_q.dot  <= DotBits'(px2_q) + DotBits'(pz2_q);
      job_q.len2 <= DotBits'(lx2_q) + DotBits'(lz2_q);
    end
  end

  assign out_valid_o = v_q[2];
  assign out_job_o   = job_q;
endmodule

### hdl/psp_queue.sv
// Short queue between the front and back parts; flip-flop storage.
// Depends on psp_pkg.
module psp_queue import psp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output logic empty_o,
  output logic [QPtrBits:0] count_o,
  output job_t head_o
);
  job_t mem_q [QDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QPtrBits:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrBits+1)'(push_i) - (QPtrBits+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_job_i;
  end

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_q];
endmodule

### hdl/psp_back.sv
// Back part: pipelined restoring divider for the ratio, then placement and clamping.
// One quotient bit per stage; depends on psp_pkg.
module psp_back import psp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  job_t in_job_i,
  input  logic adv_i,
  output logic out_valid_o,
  output res_t out_res_o
);
  localparam int unsigned NStg     = QuotBits + 4;
  localparam int unsigned HalfBits = RmagBits / 2;
  localparam int unsigned PartBits = HalfBits + DiffBits;
  localparam int unsigned MulBits  = RmagBits + DiffBits;

  logic [NStg-1:0] v_q;
  job_t job_q [QuotBits+1];
  logic [NumBits-1:0] num_q [QuotBits+1];
  logic [DotBits:0] rem_q [QuotBits+1];
  logic [QuotBits-1:0] quo_q [QuotBits+1];
  logic dneg_q [QuotBits+1];

  logic [DotBits-1:0] dmag_in;
  assign dmag_in = in_job_i.dot[DotBits-1] ? -in_job_i.dot : in_job_i.dot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv_i) v_q <= {v_q[NStg-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      job_q[0] <= in_job_i;
      num_q[0] <= {dmag_in, {RatioFrac{1'b0}}};
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      dneg_q[0] <= in_job_i.dot[DotBits-1];
    end
  end

  for (genvar g = 0; g < QuotBits; g++) begin : g_div
    logic [DotBits:0] trial;
    logic ge;
    assign trial = {rem_q[g][DotBits-1:0], num_q[g][NumBits-1]};
    assign ge = trial >= {1'b0, job_q[g].len2};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        job_q[g+1]  <= job_q[g];
        dneg_q[g+1] <= dneg_q[g];
        num_q[g+1]  <= num_q[g] << 1;
        rem_q[g+1]  <= ge ? trial - {1'b0, job_q[g].len2} : trial;
        quo_q[g+1]  <= {quo_q[g][QuotBits-2:0], ge};
      end
    end
  end

  // Multiply over two stages: the ratio magnitude is split into two halves,
  // each half times |d| is formed first, and the partial products are summed next.
  job_t jm1_q, jm_q;
  logic dn1_q, dn_q;
  logic [PartBits-1:0] pxl_q, pxh_q, pzl_q, pzh_q;
  logic [MulBits-1:0] mx_q, mz_q;
  logic [RmagBits-1:0] rmag;
  logic [QuotBits-1:0] qf;
  logic [DiffBits-1:0] adx, adz;
  job_t jf;
  assign qf = quo_q[QuotBits];
  assign jf = job_q[QuotBits];
  assign rmag = (qf > QuotBits'(1) << LimitExp) ? RmagBits'(1) << LimitExp : qf[RmagBits-1:0];
  assign adx = jf.dx[DiffBits-1] ? DiffBits'(-jf.dx) : DiffBits'(jf.dx);
  assign adz = jf.dz[DiffBits-1] ? DiffBits'(-jf.dz) : DiffBits'(jf.dz);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      jm1_q <= jf;
      dn1_q <= dneg_q[QuotBits];
      pxl_q <= PartBits'(rmag[HalfBits-1:0]) * PartBits'(adx);
      pxh_q <= PartBits'(rmag[RmagBits-1:HalfBits]) * PartBits'(adx);
      pzl_q <= PartBits'(rmag[HalfBits-1:0]) * PartBits'(adz);
      pzh_q <= PartBits'(rmag[RmagBits-1:HalfBits]) * PartBits'(adz);
      jm_q <= jm1_q;
      dn_q <= dn1_q;
      mx_q <= MulBits'(pxl_q) + (MulBits'(pxh_q) << HalfBits);
      mz_q <= MulBits'(pzl_q) + (MulBits'(pzh_q) << HalfBits);
    end
  end

  function automatic logic signed [CoordBits-1:0] place(
    input logic signed [CoordBits-1:0] s, input logic signed [DiffBits-1:0] d,
    input logic [RmagBits+DiffBits-1:0] m, input logic rneg
  );
    logic [RmagBits+DiffBits-1:0] sh;
    logic [OffBits-1:0] off;
    logic signed [CoordBits+3:0] o;
    sh = m >> RatioFrac;
    off = (sh > (RmagBits+DiffBits)'(1) << (CoordBits+2)) ?
          OffBits'(1) << (CoordBits+2) : sh[OffBits-1:0];
    o = (CoordBits+4)'({1'b0, off});
    if (d[DiffBits-1] != rneg) o = -o;
    return sat_coord((CoordBits+4)'(s) + o);
  endfunction

  res_t r_q;
  logic degen, on;
  logic signed [CoordBits-1:0] lx, lz;
  assign degen = (jm_q.len2 == '0);
  assign on = degen || (!dn_q && ({1'b0, jm_q.dot} <= {1'b0, jm_q.len2}));
  assign lx = place(jm_q.sx, jm_q.dx, mx_q, dn_q);
  assign lz = place(jm_q.sz, jm_q.dz, mz_q, dn_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q.degenerate <= degen;
      r_q.on_segment <= on;
      r_q.line_x <= degen ? jm_q.sx : lx;
      r_q.line_z <= degen ? jm_q.sz : lz;
      r_q.seg_x  <= (degen || dn_q) ? jm_q.sx : (on ? lx : jm_q.ex);
      r_q.seg_z  <= (degen || dn_q) ? jm_q.sz : (on ? lz : jm_q.ez);
    end
  end

  assign out_valid_o = v_q[NStg-1];
  assign out_res_o = r_q;
endmodule

### hdl/point_segment_projection_2d_core.sv
// Top level of the 2D point-to-segment projection core.
// Depends on psp_pkg, psp_front, psp_queue and psp_back.
//
//  channel | dir | tdata fields (lowest bit first)
//  s_axis  | in  | point_x, point_z, start_x, start_z, end_x, end_z (192 bits)
//  m_axis  | out | on_segment, seg_point_x/z, line_point_x/z, degenerate (130 -> 136 bits)
//
// One word is accepted per cycle while s_axis_tready is high. The front part forms the
// dot product and squared length in registered stages and the words then pass through the
// queue; the back part registers its input, then its divider takes one stage per quotient
// bit (QuotBits = 83), followed by two multiply stages and a place stage. Reset clears only
// valid bits and the queue's pointers and count. The front stalls only when the queue
// holds two words and the front has a valid output word; the back stalls only when its
// output word is held and unaccepted, each side on its own.
module point_segment_projection_2d_core import psp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_z, start_x, start_z, end_x, end_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // on_segment, seg_point_x, seg_point_z, line_point_x, line_point_z, degenerate, zero pad
  output logic [135:0] m_axis_tdata
);
  logic f_valid, q_empty, q_pop, f_adv, b_adv, b_valid;
  logic [QPtrBits:0] q_cnt;
  job_t f_job, q_head;
  res_t b_res;

  // Room for the three words in flight in the front part must remain in the queue.
  assign f_adv = (q_cnt <= (QPtrBits+1)'(QDepth - 3)) || !f_valid;
  assign s_axis_tready = f_adv;

  psp_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_data_i(s_axis_tdata),
    .adv_i(f_adv), .out_valid_o(f_valid), .out_job_o(f_job)
  );

  assign b_adv = !b_valid || m_axis_tready;
  assign q_pop = b_adv && !q_empty;

  psp_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid && f_adv), .push_job_i(f_job),
    .pop_i(q_pop), .empty_o(q_empty), .count_o(q_cnt), .head_o(q_head)
  );

  psp_back u_back (
    .clk_i, .rst_ni, .in_valid_i(q_pop), .in_job_i(q_head), .adv_i(b_adv),
    .out_valid_o(b_valid), .out_res_o(b_res)
  );

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata = {6'd0, b_res.degenerate, b_res.line_z, b_res.line_x,
                         b_res.seg_z, b_res.seg_x, b_res.on_segment};
endmodule

### hdl/psp_checker.sv
// Port-level checker for the projection core, bound to the top level.
// Depends on psp_pkg only for its import convention.
module psp_checker import psp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [135:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped while stalled");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[135:130] == 6'd0)
    else $error("pad bits set");
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[129] |-> m_axis_tdata[0])
    else $error("degenerate result not on segment");
  a_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[64:1] == m_axis_tdata[128:65])
    else $error("on-segment point differs from line point");
endmodule

bind point_segment_projection_2d_core psp_checker u_psp_checker (.*);
